// ----- sv/osl_pkg.sv -----
// osl_pkg: shared types, character codes and token kind tables for the operator lexer
// depends on nothing; used by every module of the block and by osl_tok_if
package osl_pkg;

	// field widths of one token
	localparam int KIND_W = 5;
	localparam int TOK_W  = 16;

	// defaults for top-level parameters
	localparam int COUNT_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// characters with a role of their own
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_NONE      = 8'h00;

	// token kinds with a role of their own
	localparam logic [KIND_W-1:0] KIND_LINE_COMMENT = 5'd27;
	localparam logic [KIND_W-1:0] KIND_STRING       = 5'd29;
	localparam logic [KIND_W-1:0] KIND_MAX          = 5'd29;
	localparam logic [KIND_W-1:0] KIND_PAIR_FIRST   = 5'd16;

	// punctuators, index is the single-char kind; the first eight may start a pair
	localparam int PAIR_LEADS = 8;
	localparam logic [7:0] OP_CHARS [16] = '{
		8'h2B, 8'h2D, 8'h3D, 8'h21, 8'h26, 8'h7C, 8'h2A, 8'h2F,
		8'h3A, 8'h3B, 8'h2E, 8'h2C, 8'h28, 8'h29, 8'h7B, 8'h7D
	};
	// followers that complete a pair, none where CH_NONE
	localparam logic [7:0] FOLLOW_A [PAIR_LEADS] = '{
		8'h2B, 8'h2D, 8'h3D, 8'h3D, 8'h26, 8'h7C, 8'h3D, 8'h2F
	};
	localparam logic [7:0] FOLLOW_B [PAIR_LEADS] = '{
		8'h3D, 8'h3D, 8'h00, 8'h00, 8'h3D, 8'h3D, 8'h00, 8'h3D
	};
	localparam logic [KIND_W-1:0] PAIR_KIND_A [PAIR_LEADS] = '{
		5'd16, 5'd18, 5'd20, 5'd21, 5'd22, 5'd24, 5'd26, 5'd27
	};
	localparam logic [KIND_W-1:0] PAIR_KIND_B [PAIR_LEADS] = '{
		5'd17, 5'd19, 5'd0, 5'd0, 5'd23, 5'd25, 5'd0, 5'd28
	};

	typedef struct packed {
		logic              hit;
		logic [KIND_W-1:0] kind;
	} kind_hit_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TOK_W-1:0]  pos;
		logic [TOK_W-1:0]  line;
		logic [TOK_W-1:0]  length;
	} token_t;

	// tokens caused by one byte, t0 first
	typedef struct packed {
		logic   two;
		token_t t0;
		token_t t1;
	} group_t;

	// front to queue write port
	typedef struct packed {
		logic   push;
		group_t grp;
	} push_t;

	// queue to back read port
	typedef struct packed {
		logic   empty;
		group_t head;
	} head_t;

	// kind of a one-char punctuator
	function automatic kind_hit_t single_kind(logic [7:0] c);
		kind_hit_t r;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			if (OP_CHARS[k] == c) begin
				r.hit  = 1'b1;
				r.kind = KIND_W'(k);
			end
		end
		return r;
	endfunction

	// kind of a two-char operator made of first and second
	function automatic kind_hit_t pair_kind(logic [7:0] first, logic [7:0] second);
		kind_hit_t s;
		kind_hit_t r;
		logic [2:0] k;
		s = single_kind(first);
		r = '0;
		k = s.kind[2:0];
		if (s.hit && s.kind < KIND_W'(PAIR_LEADS) && second != CH_NONE) begin
			if (FOLLOW_A[k] == second) begin
				r.hit  = 1'b1;
				r.kind = PAIR_KIND_A[k];
			end else if (FOLLOW_B[k] == second) begin
				r.hit  = 1'b1;
				r.kind = PAIR_KIND_B[k];
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/osl_if.sv -----
// osl_if: valid/ready channel interfaces for source bytes and tokens
// depends on osl_pkg for field widths

interface osl_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       is_last;

	modport source (output valid, output text_byte, output is_last, input ready);
	modport sink (input valid, input text_byte, input is_last, output ready);
endinterface

interface osl_tok_if;
	logic                          valid;
	logic                          ready;
	logic [osl_pkg::KIND_W-1:0]    token_kind;
	logic [osl_pkg::TOK_W-1:0]     token_pos;
	logic [osl_pkg::TOK_W-1:0]     token_line;
	logic [osl_pkg::TOK_W-1:0]     token_length;
	logic                          last_of_run;

	modport source (output valid, output token_kind, output token_pos, output token_line,
		output token_length, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_pos, input token_line,
		input token_length, input last_of_run, output ready);
endinterface

// ----- sv/osl_front.sv -----
// osl_front: takes source bytes, runs the lexer state and classifies each byte
// depends on osl_pkg and osl_text_if; writes token groups into osl_queue
module osl_front #(
	parameter int COUNT_BITS = osl_pkg::COUNT_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	osl_text_if.sink        text,
	input  logic            q_full,
	output osl_pkg::push_t  wr
);
	import osl_pkg::*;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_STRING  = 2'd1,
		MODE_COMMENT = 2'd2
	} mode_t;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	mode_t                 mode_q,        mode_n;
	logic [7:0]            pend_char_q,   pend_char_n;
	logic                  pend_valid_q,  pend_valid_n;
	logic [COUNT_BITS-1:0] pend_start_q,  pend_start_n;
	logic                  bslash_q,      bslash_n;
	logic [COUNT_BITS-1:0] str_start_q,   str_start_n;
	logic [COUNT_BITS-1:0] str_count_q,   str_count_n;
	logic [COUNT_BITS-1:0] line_q,        line_n;
	logic [COUNT_BITS-1:0] byte_q,        byte_n;

	logic      accept;
	logic      a_v, b_v;
	token_t    tok_a, tok_b;
	kind_hit_t pk, sk_pend, sk;
	logic      consumed;
	logic [7:0] c;

	function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_ONE;
	endfunction

	function automatic logic [TOK_W-1:0] fit(logic [COUNT_BITS-1:0] v);
		logic [COUNT_BITS+TOK_W-1:0] e;
		e = {{TOK_W{1'b0}}, v};
		return e[TOK_W-1:0];
	endfunction

	assign text.ready = !q_full;
	assign accept     = text.valid && text.ready;
	assign c          = text.text_byte;

	// next lexer state and the tokens this byte causes
	always_comb begin
		mode_n       = mode_q;
		pend_char_n  = pend_char_q;
		pend_valid_n = pend_valid_q;
		pend_start_n = pend_start_q;
		bslash_n     = bslash_q;
		str_start_n  = str_start_q;
		str_count_n  = str_count_q;
		line_n       = line_q;
		a_v          = 1'b0;
		b_v          = 1'b0;
		tok_a        = '0;
		tok_b        = '0;
		consumed     = 1'b0;
		pk           = pair_kind(pend_char_q, c);
		sk_pend      = single_kind(pend_char_q);
		sk           = single_kind(c);
		tok_a.line   = fit(line_q);
		tok_b.line   = fit(line_q);

		unique case (mode_q)
			MODE_STRING: begin
				tok_a.kind = KIND_STRING;
				tok_a.pos  = fit(str_start_q);
				if (c == CH_QUOTE && !bslash_q) begin
					a_v          = 1'b1;
					tok_a.length = fit(str_count_q);
					mode_n       = MODE_NORMAL;
				end else begin
					str_count_n  = sat_inc(str_count_q);
					bslash_n     = (c == CH_BACKSLASH);
					a_v          = text.is_last;
					tok_a.length = fit(str_count_n);
				end
			end
			MODE_COMMENT: begin
				if (c == CH_NEWLINE) begin
					line_n = sat_inc(line_q);
					mode_n = MODE_NORMAL;
				end
			end
			default: begin
				// resolve a waiting operator char first
				if (pend_valid_q) begin
					a_v       = 1'b1;
					tok_a.pos = fit(pend_start_q);
					if (pk.hit) begin
						tok_a.kind   = pk.kind;
						tok_a.length = TOK_W'(2);
						consumed     = 1'b1;
						if (pk.kind == KIND_LINE_COMMENT) begin
							mode_n = MODE_COMMENT;
						end
					end else begin
						tok_a.kind   = sk_pend.kind;
						tok_a.length = TOK_W'(1);
					end
					pend_valid_n = 1'b0;
					pend_char_n  = CH_NONE;
				end
				// then the current byte on its own
				if (!consumed) begin
					tok_b.pos = fit(byte_q);
					if (c == CH_NEWLINE) begin
						line_n = sat_inc(line_q);
					end else if (c == CH_QUOTE) begin
						if (text.is_last) begin
							b_v          = 1'b1;
							tok_b.kind   = KIND_STRING;
							tok_b.length = '0;
						end else begin
							mode_n      = MODE_STRING;
							str_start_n = byte_q;
							str_count_n = '0;
							bslash_n    = 1'b0;
						end
					end else if (sk.hit) begin
						if (sk.kind < KIND_W'(PAIR_LEADS) && !text.is_last) begin
							pend_valid_n = 1'b1;
							pend_char_n  = c;
							pend_start_n = byte_q;
						end else begin
							b_v          = 1'b1;
							tok_b.kind   = sk.kind;
							tok_b.length = TOK_W'(1);
						end
					end
				end
			end
		endcase

		byte_n = sat_inc(byte_q);

		// the last byte ends the text: back to the reset state
		if (text.is_last) begin
			mode_n       = MODE_NORMAL;
			pend_char_n  = CH_NONE;
			pend_valid_n = 1'b0;
			pend_start_n = '0;
			bslash_n     = 1'b0;
			str_start_n  = '0;
			str_count_n  = '0;
			line_n       = '0;
			byte_n       = '0;
		end
	end

	// group write into the queue
	always_comb begin
		wr.push   = accept && (a_v || b_v);
		wr.grp.two = a_v && b_v;
		wr.grp.t0 = a_v ? tok_a : tok_b;
		wr.grp.t1 = tok_b;
	end

	// lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_NORMAL;
			pend_char_q  <= CH_NONE;
			pend_valid_q <= 1'b0;
			pend_start_q <= '0;
			bslash_q     <= 1'b0;
			str_start_q  <= '0;
			str_count_q  <= '0;
			line_q       <= '0;
			byte_q       <= '0;
		end else if (accept) begin
			mode_q       <= mode_n;
			pend_char_q  <= pend_char_n;
			pend_valid_q <= pend_valid_n;
			pend_start_q <= pend_start_n;
			bslash_q     <= bslash_n;
			str_start_q  <= str_start_n;
			str_count_q  <= str_count_n;
			line_q       <= line_n;
			byte_q       <= byte_n;
		end
	end

endmodule

// ----- sv/osl_queue.sv -----
// osl_queue: short flop queue of token groups between front and back
// depends on osl_pkg for the group type
module osl_queue #(
	parameter int DEPTH = osl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  osl_pkg::push_t  wr,
	input  logic            pop,
	output logic            full,
	output osl_pkg::head_t  rd
);
	import osl_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	group_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full     = (count_q == CNT_FULL);
	assign rd.empty = (count_q == '0);
	assign rd.head  = mem_q[rd_ptr_q];
	assign do_pop   = pop && !rd.empty;

	// storage
	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.grp;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr.push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !wr.push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- sv/osl_back.sv -----
// osl_back: splits queued token groups into single tokens behind an output register
// depends on osl_pkg and osl_tok_if
module osl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  osl_pkg::head_t  rd,
	output logic            pop,
	osl_tok_if.source       tok
);
	import osl_pkg::*;

	logic   out_valid_q;
	token_t out_tok_q;
	logic   out_last_q;
	logic   second_q;
	logic   load;

	assign load = !out_valid_q || tok.ready;
	// a group leaves the queue with its final token
	assign pop  = load && !rd.empty && (!rd.head.two || second_q);

	assign tok.valid        = out_valid_q;
	assign tok.token_kind   = out_tok_q.kind;
	assign tok.token_pos    = out_tok_q.pos;
	assign tok.token_line   = out_tok_q.line;
	assign tok.token_length = out_tok_q.length;
	assign tok.last_of_run  = out_last_q;

	// output register and position within the head group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_tok_q   <= '0;
			out_last_q  <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= !rd.empty;
			if (!rd.empty) begin
				if (rd.head.two && !second_q) begin
					out_tok_q  <= rd.head.t0;
					out_last_q <= 1'b0;
					second_q   <= 1'b1;
				end else if (rd.head.two) begin
					out_tok_q  <= rd.head.t1;
					out_last_q <= 1'b1;
					second_q   <= 1'b0;
				end else begin
					out_tok_q  <= rd.head.t0;
					out_last_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- sv/operator_string_lexer.sv -----
// operator_string_lexer: top level of the streaming operator and string tokenizer
// depends on osl_pkg, osl_if, osl_front, osl_queue, osl_back
//
// channel  dir  modport             payload
// text     in   osl_text_if.sink    text_byte[7:0], is_last
// token    out  osl_tok_if.source   token_kind[4:0], token_pos, token_line, token_length, last_of_run
//
// one source byte is accepted every cycle while the token queue has room
// a byte that causes tokens pushes its group into the queue, and the output register then loads the first
// the output register sends one token per cycle while token.ready is high; a byte that causes
// two tokens sends them in turn, so bytes flow at one per cycle while each causes at most one
// a stalled token side fills the output register and the QUEUE_DEPTH-group queue,
// then text.ready drops
// reset clears the lexer state and empties the queue at once
module operator_string_lexer #(
	parameter int COUNT_BITS  = osl_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = osl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	osl_text_if.sink    text,
	osl_tok_if.source   token
);
	import osl_pkg::*;

	push_t wr;
	head_t rd;
	logic  q_full;
	logic  pop;

	// byte classification and lexer state
	osl_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.q_full (q_full),
		.wr     (wr)
	);

	// group queue
	osl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.full   (q_full),
		.rd     (rd)
	);

	// token output
	osl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.pop    (pop),
		.tok    (token)
	);

endmodule

// ----- sv/osl_checker.sv -----
// osl_checker: port-level assertions for operator_string_lexer, bound to the top level
// depends on osl_pkg for kind constants
module osl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        tok_valid,
	input logic                        tok_ready,
	input logic [osl_pkg::KIND_W-1:0]  tok_kind,
	input logic [osl_pkg::TOK_W-1:0]   tok_pos,
	input logic [osl_pkg::TOK_W-1:0]   tok_line,
	input logic [osl_pkg::TOK_W-1:0]   tok_length,
	input logic                        tok_last
);
	import osl_pkg::*;

	// stalled token holds
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(tok_kind) && $stable(tok_pos)
			&& $stable(tok_line) && $stable(tok_length) && $stable(tok_last))
		else $error("token changed while stalled");

	// kinds stay in the defined range
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> tok_kind <= KIND_MAX)
		else $error("token kind out of range");

	// operator lengths follow the kind
	a_op_length: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_kind != KIND_STRING |->
			(tok_kind < KIND_PAIR_FIRST && tok_length == TOK_W'(1))
			|| (tok_kind >= KIND_PAIR_FIRST && tok_length == TOK_W'(2)))
		else $error("operator length does not match kind");

	// the second token of a byte follows at once, on the same line
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_ready && !tok_last |=> tok_valid && tok_line == $past(tok_line))
		else $error("second token of a byte missing or on another line");

endmodule

bind operator_string_lexer osl_checker u_osl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tok_valid  (token.valid),
	.tok_ready  (token.ready),
	.tok_kind   (token.token_kind),
	.tok_pos    (token.token_pos),
	.tok_line   (token.token_line),
	.tok_length (token.token_length),
	.tok_last   (token.last_of_run)
);
